// ----- sv/tga_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// tga_dec_pkg
// shared types, register indexes and colour unpacking for the targa decoder
// ----------------------------------------------------------------------------
package tga_dec_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned SLOT_W  = 2;
   localparam int unsigned BPP_W   = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RLE_ENABLE  = 2'd0,
      CSR_PIXEL_BYTES = 2'd1,
      CSR_PIXEL_TOTAL = 2'd2
   } csr_index_type;

   localparam logic [BPP_W-1:0] BPP_TWO   = 3'd2;
   localparam logic [BPP_W-1:0] BPP_THREE = 3'd3;
   localparam logic [BPP_W-1:0] BPP_FOUR  = 3'd4;

   localparam logic [BYTE_W-1:0] RUN_LEN_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] ALPHA_MASK   = 8'h80;
   localparam logic [BYTE_W-1:0] RED_MASK     = 8'h7C;
   localparam logic [BYTE_W-1:0] GREEN_HI_MASK = 8'h03;
   localparam logic [BYTE_W-1:0] GREEN_LO_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] BLUE_MASK    = 8'h1F;
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  alpha;
      logic [WORD_W-1:0]  start_index;
      logic [COUNT_W-1:0] repeat_count;
      logic               image_done;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
   } rgba_type;

   // bytes per pixel, out-of-range values clamped to 2 or 4
   function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] bpp);
      logic [BPP_W-1:0] len;
      if (bpp <= BPP_TWO) begin
         len = BPP_TWO;
      end else if (bpp == BPP_THREE) begin
         len = BPP_THREE;
      end else begin
         len = BPP_FOUR;
      end
      return len;
   endfunction

   // assembled little-endian pixel word to rgba
   function automatic rgba_type pixel_to_rgba(input logic [WORD_W-1:0] word,
                                              input logic [BPP_W-1:0]  len);
      logic [BYTE_W-1:0] b0, b1, b2, b3;
      rgba_type          c;
      b0 = word[7:0];
      b1 = word[15:8];
      b2 = word[23:16];
      b3 = word[31:24];
      if (len == BPP_FOUR) begin
         c = '{red: b2, green: b1, blue: b0, alpha: b3};
      end else if (len == BPP_THREE) begin
         c = '{red: b2, green: b1, blue: b0, alpha: ALPHA_OPAQUE};
      end else begin
         // 1-5-5-5 word, each colour field widened by a left shift of three, alpha bit kept as bit 7
         c.red   = (b1 & RED_MASK) << 1;
         c.green = ((b1 & GREEN_HI_MASK) << 6) | ((b0 & GREEN_LO_MASK) >> 2);
         c.blue  = (b0 & BLUE_MASK) << 3;
         c.alpha = b1 & ALPHA_MASK;
      end
      return c;
   endfunction

endpackage

// ----- sv/tga_dec_parser.sv -----
// ----------------------------------------------------------------------------
// tga_dec_parser
// packet and pixel state of the decoder, one byte per step
// ----------------------------------------------------------------------------
module tga_dec_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [tga_dec_pkg::BYTE_W-1:0]        data_byte,
   input  logic                                  rle_enable,
   input  logic [tga_dec_pkg::BPP_W-1:0]         pixel_bytes,
   input  logic [tga_dec_pkg::WORD_W-1:0]        pixel_total,
   output logic                                  has_result,
   output tga_dec_pkg::result_type               result
);
   import tga_dec_pkg::*;

   logic                expect_header_ff, expect_header_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [WORD_W-1:0]   shift_ff, shift_in;
   logic                is_run_ff, is_run_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [WORD_W-1:0]   position_ff, position_in;

   logic [BPP_W-1:0]    len;
   logic [WORD_W-1:0]   shift_ins;
   logic [SLOT_W-1:0]   slot_next;
   logic [WORD_W-1:0]   remaining;
   logic [COUNT_W-1:0]  run_count;
   logic [COUNT_W-1:0]  count;
   logic [COUNT_W-1:0]  left_after;
   logic                done;
   rgba_type            colour;

   always_comb begin
      len        = clamp_bpp(pixel_bytes);
      shift_ins  = shift_ff | (WORD_W'(data_byte) << {slot_ff, 3'b000});
      slot_next  = slot_ff + 1'b1;
      remaining  = (position_ff < pixel_total) ? (pixel_total - position_ff)
                                               : WORD_W'(1);
      run_count  = (left_ff == '0) ? COUNT_W'(1) : left_ff;
      count      = COUNT_W'(1);
      left_after = left_ff;
      if (rle_enable) begin
         if (is_run_ff) begin
            count = (WORD_W'(run_count) > remaining) ? remaining[COUNT_W-1:0]
                                                    : run_count;
            left_after = '0;
         end else if (left_ff != '0) begin
            left_after = left_ff - 1'b1;
         end
      end
      done   = (WORD_W'(count) >= remaining);
      colour = pixel_to_rgba(shift_ins, len);

      result.red          = colour.red;
      result.green        = colour.green;
      result.blue         = colour.blue;
      result.alpha        = colour.alpha;
      result.start_index  = position_ff;
      result.repeat_count = count;
      result.image_done   = done;

      // the presented byte would complete a pixel, independent of step
      has_result       = !(rle_enable && expect_header_ff)
                         && !(slot_next != '0 && {1'b0, slot_next} < len);
      expect_header_in = expect_header_ff;
      slot_in          = slot_ff;
      shift_in         = shift_ff;
      is_run_in        = is_run_ff;
      left_in          = left_ff;
      position_in      = position_ff;

      if (step) begin
         if (rle_enable && expect_header_ff) begin
            // packet header byte
            is_run_in        = data_byte[BYTE_W-1];
            left_in          = {1'b0, data_byte[BYTE_W-2:0] & RUN_LEN_MASK[BYTE_W-2:0]}
                               + 1'b1;
            expect_header_in = 1'b0;
            slot_in          = '0;
            shift_in         = '0;
         end else if (slot_next != '0 && {1'b0, slot_next} < len) begin
            // pixel still incomplete
            slot_in  = slot_next;
            shift_in = shift_ins;
         end else begin
            slot_in     = '0;
            shift_in    = '0;
            position_in = position_ff + WORD_W'(count);
            if (rle_enable) begin
               left_in = left_after;
               if (left_after == '0) begin
                  expect_header_in = 1'b1;
               end
            end
            if (done) begin
               expect_header_in = 1'b1;
               is_run_in        = 1'b0;
               left_in          = '0;
               position_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         slot_ff          <= '0;
         shift_ff         <= '0;
         is_run_ff        <= 1'b0;
         left_ff          <= '0;
         position_ff      <= '0;
      end else begin
         expect_header_ff <= expect_header_in;
         slot_ff          <= slot_in;
         shift_ff         <= shift_in;
         is_run_ff        <= is_run_in;
         left_ff          <= left_in;
         position_ff      <= position_in;
      end
   end

endmodule

// ----- sv/tga_rle_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// a byte is held in the input register, and its result then in the result register driving rsp_
// throughput: one byte per cycle, unless a result waits on a full result register held by rsp_stall
// a byte that completes no pixel (packet header, partial pixel) gives no result
// reset: synchronous, active high; clears the stream state and loads
// rle_enable = 1, pixel_bytes = 4, pixel_total = 1
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_write_enable,
   input  logic [tga_dec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tga_dec_pkg::WORD_W-1:0]         csr_write_data,
   // byte request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tga_dec_pkg::BYTE_W-1:0]         req_data_byte,
   // pixel response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tga_dec_pkg::BYTE_W-1:0]         rsp_red,
   output logic [tga_dec_pkg::BYTE_W-1:0]         rsp_green,
   output logic [tga_dec_pkg::BYTE_W-1:0]         rsp_blue,
   output logic [tga_dec_pkg::BYTE_W-1:0]         rsp_alpha,
   output logic [tga_dec_pkg::WORD_W-1:0]         rsp_start_index,
   output logic [tga_dec_pkg::COUNT_W-1:0]        rsp_repeat_count,
   output logic                                   rsp_image_done
);
   import tga_dec_pkg::*;

   // configuration registers
   logic               rle_enable_ff;
   logic [BPP_W-1:0]   pixel_bytes_ff;
   logic [WORD_W-1:0]  pixel_total_ff;

   // input register holding one request byte
   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;

   // result register
   logic               out_valid_ff;
   result_type         out_ff;

   logic               has_result;
   result_type         result;
   logic               out_free;
   logic               advance;
   logic               req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_enable_ff  <= 1'b1;
         pixel_bytes_ff <= BPP_FOUR;
         pixel_total_ff <= WORD_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RLE_ENABLE:  rle_enable_ff  <= csr_write_data[0];
            CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_write_data[BPP_W-1:0];
            CSR_PIXEL_TOTAL: pixel_total_ff <= csr_write_data;
            default:         ;  // unmapped index, write dropped
         endcase
      end
   end

   // the result register is free when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the held byte moves on unless its result would have nowhere to go
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // packet and pixel state, stepped once per held byte
   tga_dec_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .rle_enable  (rle_enable_ff),
      .pixel_bytes (pixel_bytes_ff),
      .pixel_total (pixel_total_ff),
      .has_result  (has_result),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = out_ff.red;
   assign rsp_green        = out_ff.green;
   assign rsp_blue         = out_ff.blue;
   assign rsp_alpha        = out_ff.alpha;
   assign rsp_start_index  = out_ff.start_index;
   assign rsp_repeat_count = out_ff.repeat_count;
   assign rsp_image_done   = out_ff.image_done;

`ifndef SYNTHESIS
   // every result covers at least one pixel
   assert_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != '0))
      else $error("result with zero repeat count");

   // raw mode never yields runs
   assert_raw_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rle_enable_ff) |-> (rsp_repeat_count == COUNT_W'(1)))
      else $error("raw mode result covers more than one pixel");

   // a byte blocked by a full result register is still held next cycle
   assert_byte_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held request byte lost while blocked");

   // nothing is offered straight after reset
   assert_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !in_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/tb_tga_rle_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_top
// drives targa pixel-data bytes into the decoder in raw and run-length mode,
// keeps its own model of the parser state and compares every decoded pixel
// or run, field by field, against the expected colour, index, count and
// end-of-image flag; both handshakes idle and stall at random
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tga_dec_pkg::*;

   localparam int unsigned RANDOM_BYTES  = 950;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned LONG_HOLD     = 80;
   localparam int unsigned DRAIN_CYCLES  = 3;
   localparam int unsigned CYCLE_LIMIT   = 600000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RLE_ENABLE;
   logic [WORD_W-1:0]    csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_red;
   logic [BYTE_W-1:0]    rsp_green;
   logic [BYTE_W-1:0]    rsp_blue;
   logic [BYTE_W-1:0]    rsp_alpha;
   logic [WORD_W-1:0]    rsp_start_index;
   logic [COUNT_W-1:0]   rsp_repeat_count;
   logic                 rsp_image_done;

   // register copies, loaded with the reset values
   logic              cfg_rle   = 1'b1;
   logic [BPP_W-1:0]  cfg_bpp   = BPP_FOUR;
   logic [WORD_W-1:0] cfg_total = 32'd1;

   // parser state as the decoder should hold it
   logic              hdr_pending = 1'b1;
   logic [SLOT_W-1:0] slot_fill   = '0;
   logic [WORD_W-1:0] pixel_word  = '0;
   logic              run_pkt     = 1'b0;
   logic [COUNT_W-1:0] pkt_left   = '0;
   logic [WORD_W-1:0] image_pos   = '0;

   result_type  pixel_fifo[$];      // decoded pixels still to come out
   int unsigned bytes_sent    = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned src_idle_pct  = 20;
   int unsigned sink_idle_pct = 20;
   bit          hold_request  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned sink_run      = 0;
   bit          sink_stalling = 1'b0;

   tga_rle_pixel_decoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_start_index  (rsp_start_index),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(input int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // advance the parser model by one accepted byte, queue any pixel it completes
   task automatic predict_byte(input logic [BYTE_W-1:0] data);
      logic [BPP_W-1:0]  len;
      logic [WORD_W-1:0] left_in_image;
      logic [WORD_W-1:0] span;
      result_type        px;
      // run-length packet header: run flag and count, no pixel yet
      if (cfg_rle && hdr_pending) begin
         run_pkt     = data[7];
         pkt_left    = {1'b0, data[6:0]} + 8'd1;
         hdr_pending = 1'b0;
         slot_fill   = '0;
         pixel_word  = '0;
         return;
      end
      pixel_word = pixel_word | (32'(data) << (8 * slot_fill));
      slot_fill  = slot_fill + 2'd1;
      // sizes below two act as two, above four as four
      if (cfg_bpp <= BPP_TWO) len = BPP_TWO;
      else if (cfg_bpp == BPP_THREE) len = BPP_THREE;
      else len = BPP_FOUR;
      if (slot_fill != 2'd0 && 3'(slot_fill) < len) return;

      // a position at or past the total (zero total) counts as one pixel left
      left_in_image = (image_pos < cfg_total) ? cfg_total - image_pos : 32'd1;
      span = 32'd1;
      if (cfg_rle) begin
         if (run_pkt) begin
            span = (pkt_left == 0) ? 32'd1 : 32'(pkt_left);
            if (span > left_in_image) span = left_in_image;   // run cut at image end
            pkt_left = '0;
         end else if (pkt_left != 0) begin
            pkt_left = pkt_left - 8'd1;
         end
         if (pkt_left == 0) hdr_pending = 1'b1;
      end

      if (len == BPP_FOUR) begin
         px.red   = pixel_word[23:16];
         px.green = pixel_word[15:8];
         px.blue  = pixel_word[7:0];
         px.alpha = pixel_word[31:24];
      end else if (len == BPP_THREE) begin
         px.red   = pixel_word[23:16];
         px.green = pixel_word[15:8];
         px.blue  = pixel_word[7:0];
         px.alpha = ALPHA_OPAQUE;
      end else begin
         // 1-5-5-5 little-endian word, colour fields widened by three zero bits, alpha bit kept as bit 7
         px.red   = {pixel_word[14:10], 3'b000};
         px.green = {pixel_word[9:5], 3'b000};
         px.blue  = {pixel_word[4:0], 3'b000};
         px.alpha = {pixel_word[15], 7'b0};
      end
      px.start_index  = image_pos;
      px.repeat_count = span[COUNT_W-1:0];
      px.image_done   = (span >= left_in_image);
      pixel_fifo.push_back(px);

      slot_fill  = '0;
      pixel_word = '0;
      image_pos  = image_pos + span;
      // last pixel: back to the start of a fresh image
      if (px.image_done) begin
         hdr_pending = 1'b1;
         run_pkt     = 1'b0;
         pkt_left    = '0;
         image_pos   = '0;
      end
   endtask

   // offer one byte after a random gap and hold it until the request is taken
   task automatic send_byte(input logic [BYTE_W-1:0] data);
      int unsigned gap;
      gap = pick_gap(src_idle_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
      predict_byte(data);
   endtask

   // bytes of one pixel, lowest byte first
   task automatic send_pixel(input int unsigned len, input logic [WORD_W-1:0] value);
      for (int unsigned i = 0; i < len; i++) send_byte(value[8*i +: 8]);
   endtask

   // stop offering, wait for every pending pixel, then let the last byte settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [WORD_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_RLE_ENABLE:  cfg_rle   = value[0];
         CSR_PIXEL_BYTES: cfg_bpp   = value[BPP_W-1:0];
         CSR_PIXEL_TOTAL: cfg_total = value;
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [WORD_W-1:0] rle, input logic [WORD_W-1:0] bpp,
                            input logic [WORD_W-1:0] total);
      wait_idle();
      write_csr(CSR_RLE_ENABLE, rle);
      write_csr(CSR_PIXEL_BYTES, bpp);
      write_csr(CSR_PIXEL_TOTAL, total);
   endtask

   // reset values: run-length, four bytes, one pixel; a long run is cut to one
   task automatic test_reset_defaults();
      send_byte(8'h81);
      send_pixel(4, 32'hAA55_FF00);
   endtask

   // raw mode with a zero total, so each pixel ends its own image;
   // sizes one, two, three and five, so odd sizes below two and above four too
   task automatic test_pixel_sizes();
      configure(32'd0, 32'd1, 32'd0);
      send_pixel(2, 32'h0000_FFFF);
      configure(32'd0, 32'd2, 32'd0);
      send_pixel(2, 32'h0000_8000);
      configure(32'd0, 32'd3, 32'd0);
      send_pixel(3, 32'h007F_8000);
      configure(32'd0, 32'd5, 32'd0);
      send_pixel(4, 32'h00FF_55AA);
   endtask

   // raw packet running past the image end, a full-length run cut short,
   // and a mode change in the middle of a raw packet
   task automatic test_packet_cases();
      configure(32'd1, 32'd2, 32'd3);
      send_byte(8'h03);
      send_pixel(2, 32'h0000_7C00);
      send_pixel(2, 32'h0000_03E0);
      send_pixel(2, 32'h0000_001F);
      send_byte(8'hFF);              // left-over byte becomes the next header
      send_pixel(2, 32'h0000_FFFF);
      send_byte(8'h01);
      send_pixel(2, 32'h0000_1234);
      wait_idle();
      write_csr(CSR_RLE_ENABLE, 32'd0);
      send_pixel(2, 32'h0000_8421);
      wait_idle();
      write_csr(CSR_RLE_ENABLE, 32'd1);
      send_pixel(2, 32'h0000_5A5A);
   endtask

   // receiver holds off while bytes keep coming, so the decoder must stall
   // its input; afterwards the sender waits for every pixel
   task automatic test_backpressure();
      configure(32'd0, 32'd2, 32'd1000);
      src_idle_pct = 0;
      hold_request = 1'b1;
      repeat (48) send_byte($urandom_range(0, 255));
      wait_idle();
   endtask

   // phases of fixed and then random settings, mostly well-formed packets with random
   // content, with some loose bytes that break the packet framing
   task automatic test_random_streams();
      int unsigned      phase;
      int unsigned      phase_end;
      int unsigned      len;
      int unsigned      count;
      logic [WORD_W-1:0] total;
      logic [BYTE_W-1:0] hdr;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(32'd1, 32'd4, 32'hFFFF_FFFF);
            1: configure(32'd0, 32'd2, 32'd1);
            2: configure(32'd1, 32'd3, 32'd0);
            3: configure(32'd1, 32'd7, 32'd4294836225);
            4: configure(32'd0, 32'd0, 32'd2);
            default: begin
               case ($urandom_range(0, 5))
                  0: total = 32'd0;
                  1: total = 32'd1;
                  2: total = $urandom_range(2, 40);
                  3: total = $urandom_range(41, 600);
                  4: total = $urandom;
                  default: total = 32'hFFFF_FFFF;
               endcase
               // upper data bits are junk, only the register width counts
               configure(($urandom & ~32'h1) | $urandom_range(0, 1),
                         ($urandom & ~32'h7) | $urandom_range(0, 7), total);
            end
         endcase
         src_idle_pct  = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
         sink_idle_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 60);
         len = (cfg_bpp <= BPP_TWO) ? 2 : (cfg_bpp == BPP_THREE) ? 3 : 4;
         phase_end = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
         while (bytes_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
            end else if (cfg_rle && hdr_pending) begin
               count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 7);
               hdr = {1'($urandom_range(0, 1)), 7'(count)};
               send_byte(hdr);
               repeat (hdr[7] ? 1 : count + 1) send_pixel(len, $urandom);
            end else begin
               // raw mode, or finishing a packet already under way
               send_pixel(len, $urandom);
            end
         end
      end
   endtask

   // receiver side: random stalls, or one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_stall   <= 1'b1;
      end else begin
         if (sink_run == 0) begin
            sink_run      = pick_gap(sink_idle_pct);
            sink_stalling = (sink_run != 0);
            if (!sink_stalling) sink_run = $urandom_range(1, 8);
         end
         sink_run--;
         rsp_stall <= sink_stalling;
      end
   end

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // every pixel taken from the decoder is matched against the oldest expected one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pixel_fifo.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, got rgba %h%h%h%h at %0d x%0d",
                     $time, rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_start_index,
                     rsp_repeat_count);
            error_count++;
         end else begin
            want = pixel_fifo.pop_front();
            check_field("red", WORD_W'(want.red), WORD_W'(rsp_red));
            check_field("green", WORD_W'(want.green), WORD_W'(rsp_green));
            check_field("blue", WORD_W'(want.blue), WORD_W'(rsp_blue));
            check_field("alpha", WORD_W'(want.alpha), WORD_W'(rsp_alpha));
            check_field("start_index", want.start_index, rsp_start_index);
            check_field("repeat_count", WORD_W'(want.repeat_count),
                        WORD_W'(rsp_repeat_count));
            check_field("image_done", WORD_W'(want.image_done), WORD_W'(rsp_image_done));
         end
      end
   end

   // overall watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_pixel_sizes();
      test_packet_cases();
      test_backpressure();
      test_random_streams();
      wait_idle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/tga_dec_pkg.sv
sv/tga_dec_parser.sv
sv/tga_rle_pixel_decoder_top.sv
tb/tb_tga_rle_pixel_decoder_top.sv
